// ===== rtl/aob_pkg.sv =====
`default_nettype none

package aob_pkg;

    // Overlay store geometry
    localparam int STORE_AW    = 13;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int TEXEL_W     = 32;

    // Raster counters
    localparam int COL_W = 12;
    localparam int ROW_W = 13;
    localparam logic [ROW_W-1:0] ROW_MAX   = {ROW_W{1'b1}};
    localparam logic [12:0]      COL_LIMIT = 13'd4096;

    // Window arithmetic: signed distance from the overlay corner
    localparam int POS_W = 13;
    localparam int DIF_W = 15;

    // Default overlay size
    localparam int OVERLAY_WIDTH_DEF  = 128;
    localparam int OVERLAY_HEIGHT_DEF = 64;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_LEFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_TOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd2;
    localparam logic [12:0] LINE_WIDTH_RST = 13'd1920;

    // Input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    typedef struct packed {
        logic signed [POS_W-1:0] overlay_left;
        logic signed [POS_W-1:0] overlay_top;
        logic        [12:0]      line_width;
    } cfg_t;

    typedef struct packed {
        logic                in_window;
        logic [STORE_AW-1:0] addr;
    } raster_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } texel_t;

    typedef struct packed {
        logic       in_window;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

endpackage

`default_nettype wire

// ===== rtl/aob_store.sv =====
`default_nettype none

module aob_store (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [aob_pkg::STORE_AW-1:0] wr_addr,
    input  wire aob_pkg::texel_t              wr_data,
    input  wire logic                         rd_en,
    input  wire logic [aob_pkg::STORE_AW-1:0] rd_addr,
    output aob_pkg::texel_t                   rd_data
);
    import aob_pkg::*;

    texel_t mem [STORE_DEPTH];
    texel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/aob_raster.sv =====
`default_nettype none

module aob_raster #(
    parameter int OVERLAY_WIDTH  = aob_pkg::OVERLAY_WIDTH_DEF,
    parameter int OVERLAY_HEIGHT = aob_pkg::OVERLAY_HEIGHT_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire aob_pkg::cfg_t cfg,
    input  wire logic          step,
    input  wire logic          frame_start,
    output aob_pkg::raster_t   info
);
    import aob_pkg::*;

    localparam logic [DIF_W-1:0]    OW_LIM = DIF_W'(OVERLAY_WIDTH);
    localparam logic [DIF_W-1:0]    OH_LIM = DIF_W'(OVERLAY_HEIGHT);
    localparam logic [STORE_AW-1:0] OW_MUL = STORE_AW'(OVERLAY_WIDTH);

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [DIF_W-1:0] fx, fy;
    logic [12:0]      eff_w, col_inc;
    logic             in_x, in_y;

    // Frame start places the pixel at the origin
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;

    assign fx = {{(DIF_W-COL_W){1'b0}}, col_cur}
              - {{(DIF_W-POS_W){cfg.overlay_left[POS_W-1]}}, cfg.overlay_left};
    assign fy = {{(DIF_W-ROW_W){1'b0}}, row_cur}
              - {{(DIF_W-POS_W){cfg.overlay_top[POS_W-1]}}, cfg.overlay_top};

    assign in_x = !fx[DIF_W-1] && (fx < OW_LIM);
    assign in_y = !fy[DIF_W-1] && (fy < OH_LIM);

    assign info.in_window = in_x && in_y;
    assign info.addr      = fy[STORE_AW-1:0] * OW_MUL + fx[STORE_AW-1:0];

    // Zero or oversize width wraps at the natural column limit
    assign eff_w   = (cfg.line_width == '0 || cfg.line_width > COL_LIMIT)
                   ? COL_LIMIT : cfg.line_width;
    assign col_inc = {1'b0, col_cur} + 13'd1;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step) begin
            if (col_inc >= eff_w) begin
                col_next = '0;
                row_next = (row_cur == ROW_MAX) ? row_cur : row_cur + ROW_W'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aob_mix.sv =====
`default_nettype none

module aob_mix (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire aob_pkg::pix_t   pix_in,
    input  wire aob_pkg::texel_t texel,
    output aob_pkg::pix_t        pix_out,
    output logic [15:0]          sum_max
);
    import aob_pkg::*;

    // Exact floor(x / 255) for x below 65280 (255 * 256)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    logic [7:0]  inv_a;
    logic [15:0] sum_b_next, sum_g_next, sum_r_next;
    logic [15:0] sum_b_reg, sum_g_reg, sum_r_reg;
    pix_t        pix_a_reg;
    pix_t        out_next, out_reg;

    assign inv_a = 8'd255 - texel.alpha;

    assign sum_b_next = 16'(pix_in.blue)  * 16'(inv_a) + 16'(texel.blue)  * 16'(texel.alpha);
    assign sum_g_next = 16'(pix_in.green) * 16'(inv_a) + 16'(texel.green) * 16'(texel.alpha);
    assign sum_r_next = 16'(pix_in.red)   * 16'(inv_a) + 16'(texel.red)   * 16'(texel.alpha);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_b_reg <= sum_b_next;
            sum_g_reg <= sum_g_next;
            sum_r_reg <= sum_r_next;
            pix_a_reg <= pix_in;
        end
    end

    always_comb begin
        out_next = pix_a_reg;
        if (pix_a_reg.in_window) begin
            out_next.blue  = div255(sum_b_reg);
            out_next.green = div255(sum_g_reg);
            out_next.red   = div255(sum_r_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign pix_out = out_reg;

    // Largest pending sum, watched by the top level
    always_comb begin
        sum_max = sum_b_reg;
        if (sum_g_reg > sum_max) begin
            sum_max = sum_g_reg;
        end
        if (sum_r_reg > sum_max) begin
            sum_max = sum_r_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/alpha_overlay_blend.sv =====
`default_nettype none

// Alpha overlay blender. Load transfers (tuser command = 0) write one BGRA
// texel into an 8192-entry overlay store at texel_index; pixel transfers
// (command = 1) carry one BGR background pixel in raster order, and each
// yields exactly one result transfer. A column counter wraps at the configured
// line width (0 or above 4096 acts as 4096), the row counter saturates at
// 8191, and frame_start on a pixel restarts both at the origin. Pixels inside
// the OVERLAY_WIDTH x OVERLAY_HEIGHT window whose corner sits at the signed
// (overlay_left, overlay_top) get floor((bg*(255-a)+fg*a)/255) per channel
// and tuser = 1; all others pass unchanged with tuser = 0. The block takes
// one transfer per clock while no result is stalled, loads and pixels mixed
// freely; a pixel's result passes through the store read register, the blend
// sum register and the output register. A stalled result holds the whole
// pipeline and the input with it. The store has no reset and no clearing pass:
// load every overlay entry before a frame reaches it. A store entry is written
// and read in different cycles, since only one input transfer is taken per
// clock, so no forwarding is needed. Write the configuration registers only
// while the block is idle.
module alpha_overlay_blend #(
    parameter int OVERLAY_WIDTH  = aob_pkg::OVERLAY_WIDTH_DEF,
    parameter int OVERLAY_HEIGHT = aob_pkg::OVERLAY_HEIGHT_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // texel_index[12:0], texel_blue[20:13], texel_green[28:21],
    // texel_red[36:29], texel_alpha[44:37], back_blue[52:45],
    // back_green[60:53], back_red[68:61], zero [71:69]
    input  wire logic [aob_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0], frame_start[1]
    input  wire logic [aob_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic [aob_pkg::M_TDATA_W-1:0]        m_tdata,
    // inside_overlay[0]
    output logic [aob_pkg::M_TUSER_W-1:0]        m_tuser,
    // Configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [aob_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [12:0]                     cfg_data
);
    import aob_pkg::*;

    logic    accept, is_pixel, is_load, adv;
    logic    p1_valid_reg, p1_valid_next;
    logic    p2_valid_reg, p2_valid_next;
    logic    m_tvalid_reg, m_tvalid_next;
    cfg_t    cfg_reg, cfg_next;
    raster_t info;
    texel_t  wr_texel, rd_texel;
    pix_t    pix_in, p1_pix_reg, pix_out;
    logic [15:0] sum_max;

    // Advance the whole pipeline unless a finished result is stalled
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign is_pixel = accept && (s_tuser[0] == CMD_PIXEL);
    assign is_load  = accept && (s_tuser[0] == CMD_LOAD);

    // Configuration port never stalls
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_OVERLAY_LEFT: cfg_next.overlay_left = cfg_data;
                REG_OVERLAY_TOP:  cfg_next.overlay_top  = cfg_data;
                REG_LINE_WIDTH:   cfg_next.line_width   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overlay_left <= '0;
            cfg_reg.overlay_top  <= '0;
            cfg_reg.line_width   <= LINE_WIDTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Raster position and window lookup for the incoming pixel
    aob_raster #(
        .OVERLAY_WIDTH  (OVERLAY_WIDTH),
        .OVERLAY_HEIGHT (OVERLAY_HEIGHT)
    ) u_raster (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .step        (is_pixel),
        .frame_start (s_tuser[1]),
        .info        (info)
    );

    assign wr_texel.blue  = s_tdata[20:13];
    assign wr_texel.green = s_tdata[28:21];
    assign wr_texel.red   = s_tdata[36:29];
    assign wr_texel.alpha = s_tdata[44:37];

    // Loads write, in-window pixels read; never both in one cycle
    aob_store u_store (
        .aclk    (aclk),
        .wr_en   (is_load),
        .wr_addr (s_tdata[STORE_AW-1:0]),
        .wr_data (wr_texel),
        .rd_en   (is_pixel && info.in_window),
        .rd_addr (info.addr),
        .rd_data (rd_texel)
    );

    assign pix_in.in_window = info.in_window;
    assign pix_in.blue      = s_tdata[52:45];
    assign pix_in.green     = s_tdata[60:53];
    assign pix_in.red       = s_tdata[68:61];

    // Hold the pixel beside the store read
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_pix_reg <= pix_in;
        end
    end

    aob_mix u_mix (
        .aclk    (aclk),
        .en      (adv),
        .pix_in  (p1_pix_reg),
        .texel   (rd_texel),
        .pix_out (pix_out),
        .sum_max (sum_max)
    );

    // Valid bits follow the data; loads drop out at the first stage
    always_comb begin
        p1_valid_next = p1_valid_reg;
        p2_valid_next = p2_valid_reg;
        m_tvalid_next = m_tvalid_reg;
        if (adv) begin
            p1_valid_next = is_pixel;
            p2_valid_next = p1_valid_reg;
            m_tvalid_next = p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {pix_out.red, pix_out.green, pix_out.blue};
    assign m_tuser  = pix_out.in_window;

    // A stalled result blocks the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // Every accepted pixel enters the pipeline
    a_pixel_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_PIXEL) |=> p1_valid_reg)
        else $error("accepted pixel lost");

    // A load never occupies a pipeline slot
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_LOAD) |=> !p1_valid_reg)
        else $error("load produced a result slot");

    // Blend sums stay within the 255 * 255 range
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> (sum_max <= 16'd65025))
        else $error("blend sum out of range");

endmodule

`default_nettype wire
